[hw/rtl/aeye_pkg.sv]
package aeye_pkg;

  // Eye geometry and colors
  localparam int unsigned EYE_RX      = 60;
  localparam int unsigned EYE_RY_OPEN = 35;
  localparam int unsigned EYE_RY_SHUT = 4;
  localparam int unsigned IRIS_R      = 22;
  localparam int unsigned PUPIL_R     = 8;
  localparam int unsigned SHINE_OFS   = 7;
  localparam int unsigned SHINE_R2    = 12;

  localparam logic [15:0] IRIS_RGB  = 16'h7E59;
  localparam logic [15:0] WHITE_RGB = 16'hFFFF;
  localparam logic [15:0] BLACK_RGB = 16'h0000;

  localparam int unsigned EYE_RX2  = EYE_RX * EYE_RX;
  localparam int unsigned RY2_OPEN = EYE_RY_OPEN * EYE_RY_OPEN;
  localparam int unsigned RY2_SHUT = EYE_RY_SHUT * EYE_RY_SHUT;
  localparam int unsigned THR_OPEN = EYE_RX2 * RY2_OPEN;
  localparam int unsigned THR_SHUT = EYE_RX2 * RY2_SHUT;
  localparam int unsigned IRIS_R2  = IRIS_R * IRIS_R;
  localparam int unsigned PUPIL_R2 = PUPIL_R * PUPIL_R;

  // floor(2*a/5) == (a*410) >> 10 for every a up to 511
  localparam int unsigned LID_MUL   = 410;
  localparam int unsigned LID_SHIFT = 10;

  // Blink timing
  localparam logic [7:0] BLINK_HOLD  = 8'd3;
  localparam logic [7:0] LIMIT_RESET = 8'd50;
  localparam logic [7:0] COUNT_TOP   = 8'd255;

  // Mood codes
  localparam logic [1:0] MOOD_ANGRY = 2'd0;
  localparam logic [1:0] MOOD_FLAT  = 2'd1;
  localparam logic [1:0] MOOD_SAD   = 2'd2;

  // Input word function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // Datapath command bundle from the controller
  typedef struct packed {
    logic tick;      // apply a frame tick to the eye state
    logic capture;   // latch pixel offsets
    logic square;    // squares and lid slant
    logic scale;     // ellipse products and disc tests
    logic load_out;  // resolve color into the output register
  } dp_cmd_t;

endpackage

[hw/rtl/aeye_ctrl.sv]
module aeye_ctrl import aeye_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    func_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SCALE,
    ST_RESOLVE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_PIXEL) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_SQUARE;
          end else begin
            cmd_o.tick = 1'b1;
          end
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        // hold until the output register drains
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_pixel_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_PIXEL) |=> (state_q == ST_SQUARE) ##1 (state_q == ST_SCALE))
    else $error("pixel word did not walk through the datapath stages");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.tick, cmd_o.capture, cmd_o.square, cmd_o.scale, cmd_o.load_out}))
    else $error("more than one datapath command at once");

  a_tick_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick |=> (state_q == ST_IDLE))
    else $error("frame tick left the controller busy");

endmodule

[hw/rtl/aeye_dp.sv]
module aeye_dp import aeye_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 160,
  parameter int unsigned FRAME_HEIGHT = 80
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_mood_i,
  input  logic [7:0]        pixel_x_i,
  input  logic [6:0]        pixel_y_i,
  input  logic              force_blink_i,
  input  logic              retarget_i,
  input  logic signed [4:0] new_target_dx_i,
  input  logic signed [3:0] new_target_dy_i,
  input  logic [7:0]        next_interval_i,
  output logic [15:0]       color_o
);

  localparam logic signed [10:0] CX        = 11'(FRAME_WIDTH / 2);
  localparam logic signed [10:0] CY        = 11'(FRAME_HEIGHT / 2);
  localparam logic signed [10:0] SHINE_S   = 11'(SHINE_OFS);
  localparam logic signed [10:0] LID_ANGRY = -11'sd10;
  localparam logic signed [10:0] LID_FLAT  = -11'sd15;
  localparam logic signed [10:0] LID_SAD   = -11'sd25;

  // Eye state
  logic [1:0]        mood_q;
  logic [7:0]        count_q, count_d;
  logic [7:0]        limit_q, limit_d;
  logic              blinking_q, blinking_d;
  logic              closed_q, closed_d;
  logic signed [4:0] pupil_x_q, pupil_x_d, goal_x_q, goal_x_d;
  logic signed [3:0] pupil_y_q, pupil_y_d, goal_y_q, goal_y_d;

  // Pixel pipeline
  logic signed [10:0] dx_q, dy_q, ix_q, iy_q, hx_q, hy_q;
  logic [16:0]        dx2_q, dy2_q, ix2_q, iy2_q, hx2_q, hy2_q;
  logic [7:0]         slant_q;
  logic [27:0]        e1_q;
  logic [28:0]        e2_q;
  logic               iris_q, pupil_q, shine_q, open_q;
  logic [15:0]        color_q;

  // Frame tick next state
  always_comb begin
    count_d    = (count_q < COUNT_TOP) ? count_q + 8'd1 : count_q;
    blinking_d = blinking_q;
    limit_d    = limit_q;
    if (!blinking_d && count_d > limit_q) begin
      blinking_d = 1'b1;
      count_d    = '0;
    end
    if (force_blink_i) begin
      blinking_d = 1'b1;
      count_d    = '0;
    end
    closed_d = blinking_d;
    if (blinking_d && count_d > BLINK_HOLD) begin
      blinking_d = 1'b0;
      count_d    = '0;
      limit_d    = next_interval_i;
    end
    goal_x_d = retarget_i ? new_target_dx_i : goal_x_q;
    goal_y_d = retarget_i ? new_target_dy_i : goal_y_q;
    if (pupil_x_q < goal_x_d)      pupil_x_d = pupil_x_q + 5'sd1;
    else if (pupil_x_q > goal_x_d) pupil_x_d = pupil_x_q - 5'sd1;
    else                           pupil_x_d = pupil_x_q;
    if (pupil_y_q < goal_y_d)      pupil_y_d = pupil_y_q + 4'sd1;
    else if (pupil_y_q > goal_y_d) pupil_y_d = pupil_y_q - 4'sd1;
    else                           pupil_y_d = pupil_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mood_q     <= MOOD_ANGRY;
      count_q    <= '0;
      limit_q    <= LIMIT_RESET;
      blinking_q <= 1'b0;
      closed_q   <= 1'b0;
      pupil_x_q  <= '0;
      pupil_y_q  <= '0;
      goal_x_q   <= '0;
      goal_y_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        mood_q <= cfg_mood_i;
      end
      if (cmd_i.tick) begin
        count_q    <= count_d;
        limit_q    <= limit_d;
        blinking_q <= blinking_d;
        closed_q   <= closed_d;
        pupil_x_q  <= pupil_x_d;
        pupil_y_q  <= pupil_y_d;
        goal_x_q   <= goal_x_d;
        goal_y_q   <= goal_y_d;
      end
    end
  end

  // Capture: offsets from eye center and from pupil center
  logic signed [10:0] x_s, y_s, px_s, py_s, dx_c, dy_c, ix_c, iy_c;
  assign x_s  = $signed({3'b000, pixel_x_i});
  assign y_s  = $signed({4'b0000, pixel_y_i});
  assign px_s = 11'(pupil_x_q);
  assign py_s = 11'(pupil_y_q);
  assign dx_c = x_s - CX;
  assign dy_c = y_s - CY;
  assign ix_c = dx_c - px_s;
  assign iy_c = dy_c - py_s;

  // Square: one square per lane, lid slant from |dx|
  logic signed [21:0] dx_sq, dy_sq, ix_sq, iy_sq, hx_sq, hy_sq;
  logic [10:0]        adx;
  logic [17:0]        slant_p;
  assign dx_sq   = dx_q * dx_q;
  assign dy_sq   = dy_q * dy_q;
  assign ix_sq   = ix_q * ix_q;
  assign iy_sq   = iy_q * iy_q;
  assign hx_sq   = hx_q * hx_q;
  assign hy_sq   = hy_q * hy_q;
  assign adx     = dx_q[10] ? 11'(-dx_q) : 11'(dx_q);
  assign slant_p = 18'(adx[8:0]) * 18'(LID_MUL);

  // Scale: ellipse terms, disc tests, eyelid cut relative to eye center
  logic [17:0]        d2, s2;
  logic [10:0]        ry2;
  logic signed [10:0] slant_s, lid_off;
  logic               lid_open;
  assign d2      = 18'(ix2_q) + 18'(iy2_q);
  assign s2      = 18'(hx2_q) + 18'(hy2_q);
  assign ry2     = closed_q ? 11'(RY2_SHUT) : 11'(RY2_OPEN);
  assign slant_s = $signed({3'b000, slant_q});

  always_comb begin
    lid_off  = LID_FLAT;
    lid_open = 1'b1;
    case (mood_q)
      MOOD_ANGRY: begin
        lid_off  = LID_ANGRY - slant_s;
        lid_open = dy_q > lid_off;
      end
      MOOD_FLAT: begin
        lid_off  = LID_FLAT;
        lid_open = dy_q > lid_off;
      end
      MOOD_SAD: begin
        lid_off  = LID_SAD + slant_s;
        lid_open = dy_q > lid_off;
      end
      default: begin
        lid_open = 1'b1;
      end
    endcase
  end

  // Resolve: outline compare and color pick
  logic [29:0] lhs, thr;
  logic [15:0] color_c;
  assign lhs = 30'(e1_q) + 30'(e2_q);
  assign thr = closed_q ? 30'(THR_SHUT) : 30'(THR_OPEN);

  always_comb begin
    if (lhs > thr || !(open_q || blinking_q)) begin
      color_c = BLACK_RGB;
    end else if (!iris_q) begin
      color_c = WHITE_RGB;
    end else if (pupil_q) begin
      color_c = BLACK_RGB;
    end else if (shine_q) begin
      color_c = WHITE_RGB;
    end else begin
      color_c = IRIS_RGB;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dx_q <= dx_c;
      dy_q <= dy_c;
      ix_q <= ix_c;
      iy_q <= iy_c;
      hx_q <= ix_c + SHINE_S;
      hy_q <= iy_c + SHINE_S;
    end
    if (cmd_i.square) begin
      dx2_q   <= dx_sq[16:0];
      dy2_q   <= dy_sq[16:0];
      ix2_q   <= ix_sq[16:0];
      iy2_q   <= iy_sq[16:0];
      hx2_q   <= hx_sq[16:0];
      hy2_q   <= hy_sq[16:0];
      slant_q <= slant_p[17:LID_SHIFT];
    end
    if (cmd_i.scale) begin
      e1_q    <= 28'(dx2_q) * 28'(ry2);
      e2_q    <= 29'(dy2_q) * 29'(EYE_RX2);
      iris_q  <= d2 <= 18'(IRIS_R2);
      pupil_q <= d2 <= 18'(PUPIL_R2);
      shine_q <= s2 <= 18'(SHINE_R2);
      open_q  <= lid_open;
    end
    if (cmd_i.load_out) begin
      color_q <= color_c;
    end
  end

  assign color_o = color_q;

endmodule

[hw/rtl/animated_eye_pixel_renderer_core.sv]
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   func_i, pixel_x_i, pixel_y_i, force_blink_i,
//                                               retarget_i, new_target_dx_i, new_target_dy_i,
//                                               next_interval_i
// out      source     out_valid_o / out_stall_i color_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_mood_i
//
// A frame tick word is applied as it is taken; the next word is taken in the following cycle.
// A pixel word goes through capture, square, scale and resolve; the controller walks
// it through the shared datapath stages, so a new word is taken only once it has resolved.
// The resolved color lands in an output register; a new word is taken while it waits.
// A pixel only stalls in its resolve step while the previous color is still not taken.
// Reset (rst_ni low, asynchronous) clears the eye state and mood; no clearing pass.
module animated_eye_pixel_renderer_core import aeye_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 160,
  parameter int unsigned FRAME_HEIGHT = 80
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input words
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [7:0]        pixel_x_i,
  input  logic [6:0]        pixel_y_i,
  input  logic              force_blink_i,
  input  logic              retarget_i,
  input  logic signed [4:0] new_target_dx_i,
  input  logic signed [3:0] new_target_dy_i,
  input  logic [7:0]        next_interval_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       color_o,
  // mood register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_mood_i
);

  dp_cmd_t cmd;

  // Mood writes land directly in the mood register, so the port never pushes back.
  assign cfg_ready_o = 1'b1;

  // Controller: sequences each word through the datapath and owns the output valid.
  aeye_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Datapath: blink/pupil state, mood register, pixel stages and output color register.
  aeye_dp #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_mood_i      (cfg_mood_i),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .force_blink_i   (force_blink_i),
    .retarget_i      (retarget_i),
    .new_target_dx_i (new_target_dx_i),
    .new_target_dy_i (new_target_dy_i),
    .next_interval_i (next_interval_i),
    .color_o         (color_o)
  );

endmodule
